@@ rtl/cd_pkg.sv @@
// Shared types and constants for the circular deque.
package cd_pkg;

  localparam int DATA_W        = 32;
  localparam int CMD_W         = 3;
  localparam int CAP_W         = 5;
  localparam int DEPTH_DEFAULT = 16;
  localparam int CAP_RESET     = 16;

  localparam logic [DATA_W-1:0] EMPTY_VALUE = {DATA_W{1'b1}};

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_REAR  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_REAR   = 3'd3,
    CMD_QUERY      = 3'd4
  } cmd_t;

  // Per-cycle operation broadcast to every cell of the chain.
  typedef struct packed {
    logic push_front;
    logic push_rear;
    logic pop_front;
    logic pop_rear;
    logic clear;
  } cd_ctl_t;

endpackage

@@ rtl/circular_deque.sv @@
// Top level of the circular deque: command decode, fill count and the cell chain.
//
// Usage: raise start with command and push_value while busy is low; the
// command word is taken at that clock edge. Commands are push front, push
// rear, pop front, pop rear and query. Every accepted command gives one
// result word, registered through busy and then done: done is high for
// exactly one cycle with ok, front_value, rear_value, is_empty and is_full
// describing the deque after the command. The receiver cannot stall; a
// result must be taken as shown. When a command is accepted the cells
// shift or load; while busy is high the front word (cell 0) and the rear
// word (last occupied cell, found by an OR chain through the cells) are
// registered. busy is high only for that step, so a new command can be
// given in the same cycle as done.
// Capacity is written through capacity_we and capacity while idle; the
// user must ensure this, the block does not enforce it. A write also
// empties the deque. A capacity of 0 acts as 1 and one above DEPTH acts
// as DEPTH. Reset empties the deque, sets the capacity to 16 (limited to
// DEPTH) and needs no clearing pass, as occupancy lives in per-cell flops.
module circular_deque #(
  parameter int DEPTH = cd_pkg::DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic        [cd_pkg::CMD_W-1:0]   command,
  input  logic signed [cd_pkg::DATA_W-1:0]  push_value,
  input  logic                              capacity_we,
  input  logic        [cd_pkg::CAP_W-1:0]   capacity,
  output logic                              done,
  output logic                              ok,
  output logic signed [cd_pkg::DATA_W-1:0]  front_value,
  output logic signed [cd_pkg::DATA_W-1:0]  rear_value,
  output logic                              is_empty,
  output logic                              is_full
);

  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int CAP_RST = (cd_pkg::CAP_RESET > DEPTH) ? DEPTH : cd_pkg::CAP_RESET;

  // Fill count and saturated capacity.
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W-1:0] eff_cap;
  logic [CNT_W-1:0] cap_sat;
  logic             ok_pend;
  logic             ok_next;

  logic             accept;
  logic             cur_empty;
  logic             cur_full;
  cd_pkg::cd_ctl_t  ctl;

  assign accept    = start & ~busy;
  assign cur_empty = (count == '0);
  assign cur_full  = (count == eff_cap);

  // Capacity saturates into the range one to DEPTH.
  always_comb begin
    if (capacity == '0) begin
      cap_sat = CNT_W'(1);
    end else if (32'(capacity) > 32'(DEPTH)) begin
      cap_sat = CNT_W'(DEPTH);
    end else begin
      cap_sat = CNT_W'(capacity);
    end
  end

  // Decode the command against the current fill level.
  always_comb begin
    ctl        = '0;
    ctl.clear  = capacity_we;
    ok_next    = 1'b0;
    count_next = count;
    if (accept) begin
      case (cd_pkg::cmd_t'(command))
        cd_pkg::CMD_PUSH_FRONT: begin
          if (!cur_full) begin
            ctl.push_front = 1'b1;
            ok_next        = 1'b1;
            count_next     = count + CNT_W'(1);
          end
        end
        cd_pkg::CMD_PUSH_REAR: begin
          if (!cur_full) begin
            ctl.push_rear = 1'b1;
            ok_next       = 1'b1;
            count_next    = count + CNT_W'(1);
          end
        end
        cd_pkg::CMD_POP_FRONT: begin
          if (!cur_empty) begin
            ctl.pop_front = 1'b1;
            ok_next       = 1'b1;
            count_next    = count - CNT_W'(1);
          end
        end
        cd_pkg::CMD_POP_REAR: begin
          if (!cur_empty) begin
            ctl.pop_rear = 1'b1;
            ok_next      = 1'b1;
            count_next   = count - CNT_W'(1);
          end
        end
        cd_pkg::CMD_QUERY: begin
          ok_next = 1'b1;
        end
        default: begin
          ok_next = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      eff_cap <= CNT_W'(CAP_RST);
      busy    <= 1'b0;
      done    <= 1'b0;
    end else begin
      if (capacity_we) begin
        count   <= '0;
        eff_cap <= cap_sat;
      end else begin
        count <= count_next;
      end
      busy <= accept;
      done <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ok_pend <= ok_next;
    end
  end

  // The chain of cells; cell 0 holds the front word.
  logic signed [cd_pkg::DATA_W-1:0] cell_value [DEPTH];
  logic                             cell_occ   [DEPTH];
  logic        [cd_pkg::DATA_W-1:0] rear_chain [DEPTH+1];

  assign rear_chain[DEPTH] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [cd_pkg::DATA_W-1:0] left_value;
    logic                             left_occ;
    logic signed [cd_pkg::DATA_W-1:0] right_value;
    logic                             right_occ;

    if (i == 0) begin : g_head
      assign left_value = push_value;
      assign left_occ   = 1'b1;
    end else begin : g_mid
      assign left_value = cell_value[i-1];
      assign left_occ   = cell_occ[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_value = '0;
      assign right_occ   = 1'b0;
    end else begin : g_body
      assign right_value = cell_value[i+1];
      assign right_occ   = cell_occ[i+1];
    end

    cd_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .push_value  (push_value),
      .left_value  (left_value),
      .left_occ    (left_occ),
      .right_value (right_value),
      .right_occ   (right_occ),
      .rear_in     (rear_chain[i+1]),
      .value       (cell_value[i]),
      .occ         (cell_occ[i]),
      .rear_out    (rear_chain[i])
    );
  end

  // Result registers, loaded in the cycle after the cells have settled.
  always_ff @(posedge clk) begin
    if (busy) begin
      ok          <= ok_pend;
      is_empty    <= cur_empty;
      is_full     <= cur_full;
      front_value <= cur_empty ? cd_pkg::EMPTY_VALUE : cell_value[0];
      rear_value  <= cur_empty ? cd_pkg::EMPTY_VALUE : rear_chain[0];
    end
  end

endmodule

@@ rtl/cd_cell.sv @@
// One storage cell of the deque chain: a word and its occupied bit.
module cd_cell (
  input  logic                           clk,
  input  logic                           rst,
  input  cd_pkg::cd_ctl_t                ctl,
  input  logic signed [cd_pkg::DATA_W-1:0] push_value,
  input  logic signed [cd_pkg::DATA_W-1:0] left_value,
  input  logic                           left_occ,
  input  logic signed [cd_pkg::DATA_W-1:0] right_value,
  input  logic                           right_occ,
  input  logic        [cd_pkg::DATA_W-1:0] rear_in,
  output logic signed [cd_pkg::DATA_W-1:0] value,
  output logic                           occ,
  output logic        [cd_pkg::DATA_W-1:0] rear_out
);

  // The cell holding the rear word is the last occupied one.
  logic last;
  assign last     = occ & ~right_occ;
  assign rear_out = rear_in | (last ? value : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else if (ctl.clear) begin
      occ <= 1'b0;
    end else if (ctl.push_front) begin
      occ <= left_occ;
    end else if (ctl.push_rear) begin
      if (!occ && left_occ) begin
        occ <= 1'b1;
      end
    end else if (ctl.pop_front || ctl.pop_rear) begin
      occ <= right_occ;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push_front) begin
      value <= left_value;
    end else if (ctl.push_rear && !occ && left_occ) begin
      value <= push_value;
    end else if (ctl.pop_front) begin
      value <= right_value;
    end
  end

endmodule

@@ rtl/cd_chk.sv @@
// Port-level checker for the circular deque, bound to the top level.
module cd_chk (
  input logic                              clk,
  input logic                              rst,
  input logic                              start,
  input logic                              busy,
  input logic                              done,
  input logic signed [cd_pkg::DATA_W-1:0]  front_value,
  input logic signed [cd_pkg::DATA_W-1:0]  rear_value,
  input logic                              is_empty,
  input logic                              is_full
);

  // An accepted word is followed by a busy cycle and then its result.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted word not followed by busy cycle");

  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    busy |=> (done && !busy))
    else $error("busy cycle not followed by a result");

  // An empty deque reports both end words as all ones.
  a_empty_values: assert property (@(posedge clk) disable iff (rst)
    (done && is_empty) |-> (front_value == -32'sd1 && rear_value == -32'sd1))
    else $error("empty result with a live end word");

  a_empty_not_full: assert property (@(posedge clk) disable iff (rst)
    done |-> !(is_empty && is_full))
    else $error("result both empty and full");

endmodule

bind circular_deque cd_chk u_cd_chk (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .front_value (front_value),
  .rear_value  (rear_value),
  .is_empty    (is_empty),
  .is_full     (is_full)
);
